// ----- rtl/bclru_pkg.sv -----
// Shared types and constants for the block cache LRU tag store.
// Used by bclru_ram users, bclru_scan and block_cache_lru_lookup_top.
package bclru_pkg;

    localparam int TAG_W   = 16;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 3;

    // One stored slot entry: block tag and the tick of its last access.
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = TAG_W + STAMP_W;

    // Sequencer to scan unit.
    typedef struct packed {
        logic clear;
        logic beat;
    } scan_ctl_t;

    // Scan unit back to sequencer.
    typedef struct packed {
        logic hit_found;
        logic free_found;
    } scan_flags_t;

endpackage

// ----- rtl/block_cache_lru_lookup_top.sv -----
// Top level of the block cache LRU tag store: sequencer, valid bits, tick.
// Depends on bclru_pkg, bclru_ram and bclru_scan.

// Each request (start while busy is low) looks up one nonzero block number in
// a fully associative cache of CACHE_SLOTS slots: the tag/stamp RAM is read
// one slot per cycle through its single read port into a shared compare unit,
// then the drain state takes the last read and the update state writes the
// chosen slot. The result appears on hit, slot, evicted and evicted_block for
// exactly one cycle, marked by done, in the cycle in which busy falls; it
// cannot be held off, so capture it then. A hit
// refreshes the slot's age; a miss fills the lowest free slot, or else
// replaces the least recently used one (lowest index on ties). All slots are
// empty after reset, with no clearing pass.
module block_cache_lru_lookup_top #(
    parameter int CACHE_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] block_number,
    output logic        done,
    output logic        hit,
    output logic [2:0]  slot,
    output logic        evicted,
    output logic [15:0] evicted_block
);

    localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [IDX_W-1:0]                addr_reg;
    logic                            beat_reg;
    logic [IDX_W-1:0]                beat_idx_reg;
    logic [bclru_pkg::TAG_W-1:0]     tag_reg;
    logic [bclru_pkg::STAMP_W-1:0]   tick_reg;
    logic [CACHE_SLOTS-1:0]          valid_reg;

    logic                            done_reg;
    logic                            hit_reg;
    logic [2:0]                      slot_reg;
    logic                            evicted_reg;
    logic [bclru_pkg::TAG_W-1:0]     evicted_block_reg;

    logic                            accept;
    bclru_pkg::entry_t               rd_entry;
    bclru_pkg::entry_t               wr_entry;
    bclru_pkg::scan_ctl_t            scan_ctl;
    bclru_pkg::scan_flags_t          scan_flags;
    logic [IDX_W-1:0]                hit_idx;
    logic [IDX_W-1:0]                free_idx;
    logic [IDX_W-1:0]                victim_idx;
    logic [bclru_pkg::TAG_W-1:0]     victim_tag;
    logic [IDX_W-1:0]                chosen_idx;
    logic                            do_evict;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign scan_ctl.clear = accept;
    assign scan_ctl.beat  = beat_reg;

    assign do_evict   = !scan_flags.hit_found && !scan_flags.free_found;
    assign chosen_idx = scan_flags.hit_found  ? hit_idx  :
                        scan_flags.free_found ? free_idx : victim_idx;

    assign wr_entry.tag   = tag_reg;
    assign wr_entry.stamp = tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            beat_reg  <= 1'b0;
            tick_reg  <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            beat_reg  <= (state_reg == ST_SCAN);
            done_reg  <= (state_reg == ST_UPDATE);
            if (accept)
            begin
                addr_reg <= '0;
                tick_reg <= tick_reg + 1'b1;
            end
            else if (state_reg == ST_SCAN && addr_reg != LAST_IDX)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (state_reg == ST_UPDATE)
            begin
                valid_reg[chosen_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        beat_idx_reg <= addr_reg;
        if (accept)
        begin
            tag_reg <= block_number;
        end
        if (state_reg == ST_UPDATE)
        begin
            hit_reg           <= scan_flags.hit_found;
            slot_reg          <= 3'(chosen_idx);
            evicted_reg       <= do_evict;
            evicted_block_reg <= do_evict ? victim_tag : '0;
        end
    end

    bclru_ram #(
        .WIDTH (bclru_pkg::ENTRY_W),
        .DEPTH (CACHE_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (state_reg == ST_UPDATE),
        .waddr (chosen_idx),
        .wdata (wr_entry),
        .re    (state_reg == ST_SCAN),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    bclru_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (scan_ctl),
        .beat_idx        (beat_idx_reg),
        .beat_slot_valid (valid_reg[beat_idx_reg]),
        .beat_entry      (rd_entry),
        .tag             (tag_reg),
        .tick            (tick_reg),
        .flags           (scan_flags),
        .hit_idx         (hit_idx),
        .free_idx        (free_idx),
        .victim_idx      (victim_idx),
        .victim_tag      (victim_tag)
    );

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted       = evicted_reg;
    assign evicted_block = evicted_block_reg;

    // The strobe never lasts more than one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted))
        else $error("hit and evicted both set");

    // Eviction only when every slot was already valid
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> $past(&valid_reg))
        else $error("eviction with a free slot present");

    // After an accepted request the block is busy and done is low
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done))
        else $error("block not busy after accepting a request");

    // Result comes out right after the update cycle
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (done && !busy))
        else $error("result not presented after update");

endmodule

// ----- rtl/bclru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bclru_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bclru_scan.sv -----
// Shared compare unit: takes one slot entry per beat and keeps the first hit,
// the first free slot and the oldest slot seen so far. Depends on bclru_pkg.
module bclru_scan #(
    parameter int IDX_W = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bclru_pkg::scan_ctl_t             ctl,
    input  logic [IDX_W-1:0]                 beat_idx,
    input  logic                             beat_slot_valid,
    input  bclru_pkg::entry_t                beat_entry,
    input  logic [bclru_pkg::TAG_W-1:0]      tag,
    input  logic [bclru_pkg::STAMP_W-1:0]    tick,
    output bclru_pkg::scan_flags_t           flags,
    output logic [IDX_W-1:0]                 hit_idx,
    output logic [IDX_W-1:0]                 free_idx,
    output logic [IDX_W-1:0]                 victim_idx,
    output logic [bclru_pkg::TAG_W-1:0]      victim_tag
);

    logic                           hit_found_reg;
    logic                           free_found_reg;
    logic [IDX_W-1:0]               hit_idx_reg;
    logic [IDX_W-1:0]               free_idx_reg;
    logic [IDX_W-1:0]               victim_idx_reg;
    logic [bclru_pkg::TAG_W-1:0]    victim_tag_reg;
    logic [bclru_pkg::STAMP_W-1:0]  best_age_reg;

    logic                           first_beat;
    logic                           tag_match;
    logic [bclru_pkg::STAMP_W-1:0]  age;
    logic                           take_victim;

    assign first_beat  = (beat_idx == '0);
    assign tag_match   = beat_slot_valid && (beat_entry.tag == tag);
    // Age modulo 2^32 keeps the ordering right across a tick wrap
    assign age         = tick - beat_entry.stamp;
    assign take_victim = first_beat || (age > best_age_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.beat)
        begin
            if (tag_match)
            begin
                hit_found_reg <= 1'b1;
            end
            if (!beat_slot_valid)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.beat)
        begin
            if (tag_match && !hit_found_reg)
            begin
                hit_idx_reg <= beat_idx;
            end
            if (!beat_slot_valid && !free_found_reg)
            begin
                free_idx_reg <= beat_idx;
            end
            if (take_victim)
            begin
                best_age_reg   <= age;
                victim_idx_reg <= beat_idx;
                victim_tag_reg <= beat_entry.tag;
            end
        end
    end

    assign flags.hit_found  = hit_found_reg;
    assign flags.free_found = free_found_reg;
    assign hit_idx          = hit_idx_reg;
    assign free_idx         = free_idx_reg;
    assign victim_idx       = victim_idx_reg;
    assign victim_tag       = victim_tag_reg;

endmodule
